// ----- src/qrt_pkg.sv -----
// Shared types, codes and helpers for the query retry tracker.
package qrt_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RESP  = 2'd1;
   localparam logic [1:0] OP_SEND  = 2'd2;
   localparam logic [1:0] OP_SWEEP = 2'd3;

   localparam logic [1:0] KIND_SERVER = 2'd0;
   localparam logic [1:0] KIND_MASTER = 2'd1;
   localparam logic [1:0] KIND_BCAST  = 2'd2;
   localparam logic [1:0] KIND_BAD    = 2'd3;

   localparam logic [1:0] ST_QUEUED    = 2'd0;
   localparam logic [1:0] ST_QUERIED   = 2'd1;
   localparam logic [1:0] ST_RESPONDED = 2'd2;
   localparam logic [1:0] ST_NORESP    = 2'd3;

   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_SEND_SERVER = 3'd1;
   localparam logic [2:0] EV_SEND_BCAST  = 3'd2;
   localparam logic [2:0] EV_SEND_MASTER = 3'd3;
   localparam logic [2:0] EV_NEW_RESP    = 3'd4;
   localparam logic [2:0] EV_FULL        = 3'd5;

   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_MAX_ATT  = 2'd1;
   localparam int         CSR_DATA_W   = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [7:0]  MAX_ATT_RESET = 8'd3;
   localparam logic [7:0]  ATT_SAT       = 8'd255;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [31:0] addr_key;
      logic [1:0]  target_kind;
      logic        header_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  target_index;
      logic [31:0] target_addr;
      logic [31:0] ping_ms;
      logic        all_done;
      logic [4:0]  responder_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] sent_time;
      logic [7:0]  attempts;
   } entry_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_COMMIT
   } fsm_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic out_free;
   } stat_type;

   function automatic logic is_done(input logic [1:0] status);
      return (status == ST_RESPONDED) || (status == ST_NORESP);
   endfunction

   function automatic logic is_resp(input entry_type e);
      return (e.kind == KIND_SERVER) && (e.status == ST_RESPONDED);
   endfunction

endpackage

// ----- src/qrt_ctrl.sv -----
// Sequencer: accept, scan the table, commit the result.
module qrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrt_pkg::stat_type stat,
   output qrt_pkg::cmd_type  cmd
);

   qrt_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qrt_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         qrt_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = qrt_pkg::FSM_SCAN;
            end
         end
         qrt_pkg::FSM_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.last) begin
               state_in = qrt_pkg::FSM_COMMIT;
            end
         end
         qrt_pkg::FSM_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = qrt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = qrt_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

// ----- src/qrt_dp.sv -----
// Datapath: target table, scan pipeline, counters and result register.
module qrt_dp #(
   parameter int MAX_TARGETS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qrt_pkg::req_type               req_data,
   input  qrt_pkg::cmd_type               cmd,
   output qrt_pkg::stat_type              stat,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [qrt_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output qrt_pkg::rsp_type               rsp_data
);

   localparam int CW = $clog2(MAX_TARGETS + 1);
   localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

   qrt_pkg::entry_type entry_mem [MAX_TARGETS];

   qrt_pkg::req_type   req_ff;
   logic [CW-1:0]      rd_idx_ff, chk_idx_ff, found_idx_ff;
   logic               chk_vld_ff, found_ff;
   qrt_pkg::entry_type rd_data_ff, found_ent_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      done_cnt_ff, done_cnt_in;
   logic [CW-1:0]      resp_cnt_ff, resp_cnt_in;
   logic [15:0]        timeout_ff;
   logic [7:0]         max_att_ff;
   qrt_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic               timed_out, key_hit, send_hit, sweep_hit, match;
   logic               can_append, append;
   logic               wr_en, has_old;
   logic [IW-1:0]      wr_addr;
   qrt_pkg::entry_type wr_data, old_ent;
   logic [1:0]         kind_norm;
   logic [CW-1:0]      idx_res;

   assign timed_out = (req_ff.now_ms - rd_data_ff.sent_time) > {16'd0, timeout_ff};
   assign key_hit   = rd_data_ff.key == req_ff.addr_key;
   assign send_hit  = (rd_data_ff.status == qrt_pkg::ST_QUEUED) ||
                      ((rd_data_ff.status == qrt_pkg::ST_QUERIED) && timed_out);
   assign sweep_hit = (rd_data_ff.status == qrt_pkg::ST_QUERIED) &&
                      (rd_data_ff.attempts >= max_att_ff) && timed_out;

   always_comb begin
      match = 1'b0;
      unique case (req_ff.opcode)
         qrt_pkg::OP_ADD, qrt_pkg::OP_RESP: match = chk_vld_ff && key_hit;
         qrt_pkg::OP_SEND:                  match = chk_vld_ff && send_hit;
         default:                           match = 1'b0;
      endcase
   end

   assign stat.hit      = match;
   assign stat.last     = (count_ff == '0) ||
                          (chk_vld_ff && (chk_idx_ff == count_ff - CW'(1)));
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign can_append = count_ff < CW'(MAX_TARGETS);
   assign kind_norm  = (req_ff.target_kind == qrt_pkg::KIND_BAD) ?
                       qrt_pkg::KIND_SERVER : req_ff.target_kind;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = found_idx_ff[IW-1:0];
      wr_data = found_ent_ff;
      has_old = 1'b0;
      old_ent = found_ent_ff;
      append  = 1'b0;
      idx_res = '0;
      rsp_in  = '0;
      if (cmd.scan && chk_vld_ff && (req_ff.opcode == qrt_pkg::OP_SWEEP) && sweep_hit) begin
         wr_en          = 1'b1;
         wr_addr        = chk_idx_ff[IW-1:0];
         wr_data        = rd_data_ff;
         wr_data.status = qrt_pkg::ST_NORESP;
         has_old        = 1'b1;
         old_ent        = rd_data_ff;
      end
      if (cmd.commit) begin
         unique case (req_ff.opcode)
            qrt_pkg::OP_ADD: begin
               rsp_in.target_addr = req_ff.addr_key;
               if (found_ff) begin
                  wr_en        = 1'b1;
                  has_old      = 1'b1;
                  wr_data.kind = kind_norm;
                  idx_res      = found_idx_ff;
               end else if (can_append) begin
                  wr_en   = 1'b1;
                  append  = 1'b1;
                  wr_addr = count_ff[IW-1:0];
                  wr_data = '{key: req_ff.addr_key, kind: kind_norm,
                              status: qrt_pkg::ST_QUEUED, sent_time: 32'd0,
                              attempts: 8'd0};
                  idx_res = count_ff;
               end else begin
                  rsp_in.event_res = qrt_pkg::EV_FULL;
               end
            end
            qrt_pkg::OP_RESP: begin
               if (req_ff.header_ok) begin
                  if (found_ff && (found_ent_ff.kind == qrt_pkg::KIND_MASTER)) begin
                     wr_en          = 1'b1;
                     has_old        = 1'b1;
                     wr_data.status = qrt_pkg::ST_RESPONDED;
                  end else if (found_ff) begin
                     idx_res            = found_idx_ff;
                     rsp_in.target_addr = req_ff.addr_key;
                     if (found_ent_ff.status != qrt_pkg::ST_RESPONDED) begin
                        wr_en            = 1'b1;
                        has_old          = 1'b1;
                        wr_data.status   = qrt_pkg::ST_RESPONDED;
                        rsp_in.ping_ms   = req_ff.now_ms - found_ent_ff.sent_time;
                        rsp_in.event_res = qrt_pkg::EV_NEW_RESP;
                     end
                  end else if (can_append) begin
                     wr_en   = 1'b1;
                     append  = 1'b1;
                     wr_addr = count_ff[IW-1:0];
                     wr_data = '{key: req_ff.addr_key, kind: qrt_pkg::KIND_SERVER,
                                 status: qrt_pkg::ST_RESPONDED, sent_time: 32'd0,
                                 attempts: 8'd0};
                     idx_res            = count_ff;
                     rsp_in.target_addr = req_ff.addr_key;
                     rsp_in.ping_ms     = req_ff.now_ms;
                     rsp_in.event_res   = qrt_pkg::EV_NEW_RESP;
                  end else begin
                     rsp_in.event_res   = qrt_pkg::EV_FULL;
                     rsp_in.target_addr = req_ff.addr_key;
                  end
               end
            end
            qrt_pkg::OP_SEND: begin
               if (found_ff) begin
                  wr_en             = 1'b1;
                  has_old           = 1'b1;
                  wr_data.status    = qrt_pkg::ST_QUERIED;
                  wr_data.sent_time = req_ff.now_ms;
                  if (found_ent_ff.attempts != qrt_pkg::ATT_SAT) begin
                     wr_data.attempts = found_ent_ff.attempts + 8'd1;
                  end
                  idx_res            = found_idx_ff;
                  rsp_in.target_addr = found_ent_ff.key;
                  priority if (found_ent_ff.kind == qrt_pkg::KIND_BCAST) begin
                     rsp_in.event_res = qrt_pkg::EV_SEND_BCAST;
                  end else if (found_ent_ff.kind == qrt_pkg::KIND_MASTER) begin
                     rsp_in.event_res = qrt_pkg::EV_SEND_MASTER;
                  end else begin
                     rsp_in.event_res = qrt_pkg::EV_SEND_SERVER;
                  end
               end
            end
            default: begin
               rsp_in.event_res = qrt_pkg::EV_NONE;
            end
         endcase
      end
      count_in    = count_ff + CW'(append);
      done_cnt_in = done_cnt_ff - CW'(has_old && qrt_pkg::is_done(old_ent.status))
                    + CW'(wr_en && qrt_pkg::is_done(wr_data.status));
      resp_cnt_in = resp_cnt_ff - CW'(has_old && qrt_pkg::is_resp(old_ent))
                    + CW'(wr_en && qrt_pkg::is_resp(wr_data));
      rsp_in.target_index    = 4'(idx_res);
      rsp_in.all_done        = done_cnt_in == count_in;
      rsp_in.responder_count = 5'(resp_cnt_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         chk_idx_ff <= rd_idx_ff;
      end
      if (cmd.scan && match) begin
         found_idx_ff <= chk_idx_ff;
         found_ent_ff <= rd_data_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         done_cnt_ff  <= '0;
         resp_cnt_ff  <= '0;
         timeout_ff   <= qrt_pkg::TIMEOUT_RESET;
         max_att_ff   <= qrt_pkg::MAX_ATT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            chk_vld_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else if (cmd.scan) begin
            rd_idx_ff  <= rd_idx_ff + CW'(1);
            chk_vld_ff <= rd_idx_ff < count_ff;
            if (match) begin
               found_ff <= 1'b1;
            end
         end
         count_ff    <= count_in;
         done_cnt_ff <= done_cnt_in;
         resp_cnt_ff <= resp_cnt_in;
         if (csr_wr_en && (csr_index == qrt_pkg::CSR_TIMEOUT)) begin
            timeout_ff <= csr_wr_data;
         end
         if (csr_wr_en && (csr_index == qrt_pkg::CSR_MAX_ATT)) begin
            max_att_ff <= csr_wr_data[7:0];
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/query_retry_tracker.sv -----
// Query retry tracker top level: sequencer plus table datapath.
//
// Request channel (req_valid/req_stall/req_data): one transaction per
// opcode: add target, response received, send tick or timeout sweep.
// Result channel (rsp_valid/rsp_stall/rsp_data): exactly one result
// transaction per request, in request order.
// CSR port: csr_wr_en writes csr_wr_data into register csr_index
// (0 timeout_ms, 1 max_attempts); other indexes are ignored.
// The scan reads at most the fill count of table entries, one entry per
// cycle through the table memory's single read port. One request is in
// flight at a time; a new request is accepted only after the previous
// one has been committed.
// A finished result sits in the output register; the next request is
// accepted while it waits, and its own result is held back until the
// receiver takes the previous one. rsp_data holds while rsp_stall is high.
// Reset clears the fill count, counters, the result valid and restores the
// CSR defaults; table contents need no clearing.
module query_retry_tracker #(
   parameter int MAX_TARGETS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  qrt_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output qrt_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [qrt_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   qrt_pkg::cmd_type  cmd;
   qrt_pkg::stat_type stat;

   qrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   qrt_dp #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- src/qrt_checker.sv -----
// Port-level checks for the query retry tracker.
module qrt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qrt_pkg::rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ping_only_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_res != qrt_pkg::EV_NEW_RESP)) |->
      (rsp_data.ping_ms == 32'd0))
      else $error("ping reported without new responder");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_res == qrt_pkg::EV_FULL)) |->
      (rsp_data.target_index == 4'd0))
      else $error("table full result carries an index");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result in the cycle after acceptance");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind query_retry_tracker qrt_checker u_qrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
